FILE: hw/rtl/ps2mq_pkg.sv
// ps2mq_pkg: shared sizes, codes and helpers for the mouse packet queue.
// No dependencies; imported by the assembler, the top level and the bench.
`default_nettype none

package ps2mq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int EV_W        = 22;   // x[8:0], y[18:9], buttons[21:19]

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [7:0] ST_OUT_FULL = 8'h01;
    localparam logic [7:0] ST_AUX      = 8'h20;
    localparam logic [7:0] HDR_SYNC    = 8'h08;
    localparam logic [7:0] HDR_OVF     = 8'hC0;
    localparam logic [7:0] HDR_XSIGN   = 8'h10;
    localparam logic [7:0] HDR_YSIGN   = 8'h20;
    localparam logic [7:0] HDR_BTN     = 8'h07;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [2:0] {
        PH_HDR = 3'b001,
        PH_X   = 3'b010,
        PH_Y   = 3'b100
    } phase_t;

    // event write request from the packet assembler
    typedef struct packed {
        logic            wr;
        logic [EV_W-1:0] data;
    } ev_wr_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ps2mq_ram.sv
// ps2mq_ram: generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
`default_nettype none

module ps2mq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];   // held while re is low
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ps2mq_pkt.sv
// ps2mq_pkt: three-byte packet assembler; filters bytes, decodes movement.
// Depends on ps2mq_pkg.
`default_nettype none

module ps2mq_pkt (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_en,
    input  wire logic [7:0]        ctrl_status,
    input  wire logic [7:0]        rx_byte,
    output ps2mq_pkg::ev_wr_t      ev
);
    import ps2mq_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;
    logic       use_byte;
    logic [8:0] x9;
    logic [9:0] y10;
    logic [9:0] y_neg;

    assign use_byte = byte_en && ((ctrl_status & ST_OUT_FULL) != 8'h00)
                      && ((ctrl_status & ST_AUX) != 8'h00);

    assign x9    = {((header_reg & HDR_XSIGN) != 8'h00), x_reg};
    assign y10   = {{2{((header_reg & HDR_YSIGN) != 8'h00)}}, rx_byte};
    assign y_neg = 10'd0 - y10;

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_next      = x_reg;
        ev.wr       = 1'b0;
        ev.data     = {header_reg[2:0] & HDR_BTN[2:0], y_neg, x9};
        if (use_byte) begin
            case (phase_reg)
                PH_X: begin
                    x_next     = rx_byte;
                    phase_next = PH_Y;
                end
                PH_Y: begin
                    phase_next = PH_HDR;
                    ev.wr      = ((header_reg & HDR_OVF) == 8'h00);
                end
                default: begin
                    // waiting for a header; needs the sync bit
                    phase_next = PH_HDR;
                    if ((rx_byte & HDR_SYNC) != 8'h00) begin
                        header_next = rx_byte;
                        phase_next  = PH_X;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            header_reg <= 8'h00;
            x_reg      <= 8'h00;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_reg      <= x_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ps2_mouse_packet_queue_core.sv
// ps2_mouse_packet_queue_core: top level; mouse packet assembler feeding an
// event ring queue held in RAM. Depends on ps2mq_pkg, ps2mq_pkt, ps2mq_ram.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  s_      | in  | s_tvalid/tready  | tuser: op; tdata: ctrl_status, rx_byte
//  m_      | out | m_tvalid/tready  | tuser: popped; tdata: move_x, move_y,
//          |     |                  |   button_bits, queue_nonempty
//
// Each item gives one result after passing through the issue stage (RAM read
// launched for a pop) and then the output register.
// A new item is taken every cycle while results are drained; the issue stage
// waits out the RAM's registered read port.
// A stall on m_ backs up into the issue stage and then drops s_tready.
// Synchronous active-low reset clears phase, pointers and valids; the event
// RAM itself is not cleared, since only written entries are ever popped.
`default_nettype none

module ps2_mouse_packet_queue_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] ctrl_status, [15:8] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [8:0] move_x, [18:9] move_y,
                                        // [21:19] button_bits,
                                        // [22] queue_nonempty, [23] zero
    output logic      [0:0]  m_tuser    // [0] popped
);
    import ps2mq_pkg::*;

    // handshakes
    logic accept;
    logic out_adv;
    logic stg_adv;

    // queue pointers
    ptr_t wr_ptr_reg, wr_ptr_next;
    ptr_t rd_ptr_reg, rd_ptr_next;
    logic do_wr;
    logic do_pop;

    ev_wr_t          ev;
    logic [EV_W-1:0] rdata;

    // issue stage: waits for the RAM read data
    logic stg_valid_reg, stg_valid_next;
    logic stg_pop_reg,   stg_pop_next;
    logic stg_ne_reg,    stg_ne_next;

    // output register
    logic            m_valid_reg, m_valid_next;
    logic            m_pop_reg,   m_pop_next;
    logic [EV_W:0]   m_data_reg,  m_data_next;

    assign out_adv  = !m_valid_reg || m_tready;
    assign stg_adv  = stg_valid_reg && out_adv;
    assign s_tready = !stg_valid_reg || out_adv;
    assign accept   = s_tvalid && s_tready;

    ps2mq_pkt u_pkt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (accept && (s_tuser[0] == OP_BYTE)),
        .ctrl_status (s_tdata[7:0]),
        .rx_byte     (s_tdata[15:8]),
        .ev          (ev)
    );

    // queue keeps one slot free; a full queue drops the new event
    assign do_wr  = ev.wr && (ptr_inc(wr_ptr_reg) != rd_ptr_reg);
    assign do_pop = accept && (s_tuser[0] == OP_POP) && (rd_ptr_reg != wr_ptr_reg);

    // writes and reads never hit the same live entry in one cycle: a pop
    // needs rd != wr, and the read data is held in the RAM output register
    ps2mq_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (do_wr),
        .waddr (wr_ptr_reg),
        .wdata (ev.data),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_comb begin
        wr_ptr_next = do_wr  ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;

        stg_valid_next = stg_valid_reg && !stg_adv;
        stg_pop_next   = stg_pop_reg;
        stg_ne_next    = stg_ne_reg;
        if (accept) begin
            stg_valid_next = 1'b1;
            stg_pop_next   = do_pop;
            stg_ne_next    = (rd_ptr_next != wr_ptr_next);
        end

        m_valid_next = m_valid_reg && !m_tready;
        m_pop_next   = m_pop_reg;
        m_data_next  = m_data_reg;
        if (stg_adv) begin
            m_valid_next = 1'b1;
            m_pop_next   = stg_pop_reg;
            m_data_next  = {stg_ne_reg, stg_pop_reg ? rdata : {EV_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        stg_pop_reg <= stg_pop_next;
        stg_ne_reg  <= stg_ne_next;
        m_pop_reg   <= m_pop_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {1'b0, m_data_reg};
    assign m_tuser[0] = m_pop_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ps2mq_checker.sv
// ps2mq_checker: port-level assertions for the mouse packet queue, bound to
// the top level. Depends on ps2_mouse_packet_queue_core.
`default_nettype none

module ps2mq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no event returned means zero movement and buttons
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[21:0] == 22'd0)
        else $error("non-pop result carries event fields");

    // pad bit stays clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[23])
        else $error("pad bit set");

    // nothing leaves without an item in flight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ps2_mouse_packet_queue_core ps2mq_checker u_ps2mq_checker (.*);

`default_nettype wire

FILE: bench/ps2_mouse_packet_queue_core_test.sv
// ps2_mouse_packet_queue_core_test: self-checking bench for the mouse packet queue.
// Drives controller bytes and pop items and predicts every result from its own model.
// Depends on ps2mq_pkg and ps2_mouse_packet_queue_core.
`timescale 1ns / 1ps

module ps2_mouse_packet_queue_core_test;

    import ps2mq_pkg::*;

    // one expected result item
    typedef struct packed {
        logic       popped;
        logic [8:0] move_x;
        logic [9:0] move_y;
        logic [2:0] buttons;
        logic       nonempty;
    } mouse_report_t;

    typedef struct packed {
        logic [8:0] x;
        logic [9:0] y;
        logic [2:0] buttons;
    } mouse_event_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] ctrl_status, [15:8] rx_byte
    logic [0:0]  s_tuser  = '0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [8:0] move_x, [18:9] move_y, [21:19] buttons,
                                   // [22] queue_nonempty, [23] zero
    logic [0:0]  m_tuser;          // [0] popped

    ps2_mouse_packet_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // predicted state of the assembler and the ring queue
    phase_t       asm_phase = PH_HDR;
    logic [7:0]   hdr_hold  = '0;
    logic [7:0]   x_hold    = '0;
    mouse_event_t event_ring [QUEUE_DEPTH];
    ptr_t         wr_ptr    = '0;
    ptr_t         rd_ptr    = '0;

    mouse_report_t expected_reports [$];
    int  mismatches  = 0;
    bit  steady      = 1'b0;   // no idling on either side while set
    int  items_sent  = 0;
    int  events_kept = 0;
    int  full_drops  = 0;
    int  ovf_drops   = 0;
    int  pops_hit    = 0;
    int  pops_empty  = 0;

    // works out the result of one accepted item and advances the predicted state
    task automatic decode_item(input logic op, input logic [7:0] st, input logic [7:0] b);
        mouse_report_t r;
        mouse_event_t  ev;
        logic [9:0]    y_ext;
        ptr_t          nxt;
        r = '0;
        if (op == OP_BYTE) begin
            if ((st & ST_OUT_FULL) != 8'h00 && (st & ST_AUX) != 8'h00) begin
                case (asm_phase)
                    PH_X: begin
                        x_hold    = b;
                        asm_phase = PH_Y;
                    end
                    PH_Y: begin
                        asm_phase = PH_HDR;
                        if ((hdr_hold & HDR_OVF) != 8'h00) begin
                            ovf_drops++;
                        end else begin
                            ev.x       = {(hdr_hold & HDR_XSIGN) != 8'h00, x_hold};
                            y_ext      = {{2{(hdr_hold & HDR_YSIGN) != 8'h00}}, b};
                            ev.y       = 10'd0 - y_ext;
                            ev.buttons = hdr_hold[2:0] & HDR_BTN[2:0];
                            nxt = (wr_ptr == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0)
                                                                      : wr_ptr + ptr_t'(1);
                            if (nxt != rd_ptr) begin
                                event_ring[wr_ptr] = ev;
                                wr_ptr = nxt;
                                events_kept++;
                            end else begin
                                full_drops++;
                            end
                        end
                    end
                    default: begin
                        asm_phase = PH_HDR;
                        if ((b & HDR_SYNC) != 8'h00) begin
                            hdr_hold  = b;
                            asm_phase = PH_X;
                        end
                    end
                endcase
            end
        end else if (rd_ptr != wr_ptr) begin
            ev        = event_ring[rd_ptr];
            r.popped  = 1'b1;
            r.move_x  = ev.x;
            r.move_y  = ev.y;
            r.buttons = ev.buttons;
            rd_ptr = (rd_ptr == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : rd_ptr + ptr_t'(1);
            pops_hit++;
        end else begin
            pops_empty++;
        end
        r.nonempty = (rd_ptr != wr_ptr);
        expected_reports.push_back(r);
    endtask

    // sends one item; entered and left at a falling edge
    task automatic send_item(input logic op, input logic [7:0] st, input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, st};
        do @(posedge aclk); while (!s_tready);
        decode_item(op, st, b);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] mouse_status();
        return 8'($urandom) | ST_OUT_FULL | ST_AUX;
    endfunction

    // status with output-full or aux cleared, so the byte is ignored
    function automatic logic [7:0] foreign_status();
        logic [7:0] s;
        s = 8'($urandom);
        if ($urandom_range(0, 1) == 0) s = s & ~ST_OUT_FULL;
        else                          s = s & ~ST_AUX;
        return s;
    endfunction

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x,
                               input logic [7:0] y);
        send_item(OP_BYTE, mouse_status(), hdr);
        send_item(OP_BYTE, mouse_status(), x);
        send_item(OP_BYTE, mouse_status(), y);
    endtask

    task automatic pop_event();
        send_item(OP_POP, 8'($urandom), 8'($urandom));
    endtask

    // holds the sender back until every outstanding result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // empty pop, bytes from the keyboard side or without output full, unsynced header
    task automatic test_ignored_bytes();
        pop_event();
        send_item(OP_BYTE, ST_AUX, HDR_SYNC);
        send_item(OP_BYTE, ST_OUT_FULL, HDR_SYNC);
        send_item(OP_BYTE, mouse_status(), 8'hF7);
        send_item(OP_BYTE, mouse_status(), 8'h00);
    endtask

    // movement and button extremes, overflow headers, an ignored byte between packets
    task automatic test_packet_extremes();
        send_packet(8'h08, 8'h00, 8'h00);
        send_item(OP_BYTE, HDR_SYNC | HDR_OVF, 8'hFF);   // status lacks output full
        send_item(OP_BYTE, ST_OUT_FULL | ST_AUX, 8'hFF);  // header, both overflow flags
        send_item(OP_BYTE, ST_OUT_FULL | ST_AUX, 8'hFF);  // X byte
        send_item(OP_BYTE, ST_OUT_FULL | ST_AUX, 8'hFF);  // Y byte; packet dropped
        send_packet(8'h3F, 8'h00, 8'h00);
        send_packet(8'h3F, 8'hFF, 8'hFF);
        send_packet(8'h48, 8'h12, 8'h34);
        send_packet(8'hB8, 8'h56, 8'h78);
        repeat (4) pop_event();
    endtask

    // overrun the queue, then empty it completely
    task automatic test_queue_full();
        wait_drained();
        steady = 1'b1;
        repeat (QUEUE_DEPTH + 2) send_packet(8'($urandom) & ~HDR_OVF | HDR_SYNC,
                                              8'($urandom), 8'($urandom));
        steady = 1'b0;
        repeat (QUEUE_DEPTH + 2) pop_event();
    endtask

    // mostly well-formed packets with random content, alternating fill and drain spells,
    // with stray bytes and cut-short packets mixed in
    task automatic test_random_traffic();
        int counted;
        int pop_pct;
        int roll;
        counted = 0;
        while (items_sent < 1600) begin
            pop_pct = ((counted / 400) % 2 == 0) ? 5 : 70;
            steady  = (counted >= 700 && counted < 850);
            roll    = $urandom_range(0, 99);
            if (roll < 10) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_BYTE, mouse_status(), 8'($urandom));
                else
                    send_item(OP_BYTE, foreign_status(), 8'($urandom));
            end else if (roll < 10 + pop_pct) begin
                pop_event();
                counted++;
            end else if ($urandom_range(0, 19) == 0) begin
                send_item(OP_BYTE, mouse_status(), 8'($urandom) | HDR_SYNC);
                send_item(OP_BYTE, mouse_status(), 8'($urandom));
                counted += 2;
            end else begin
                send_packet(($urandom_range(0, 9) == 0) ? 8'($urandom) | HDR_SYNC
                                                        : 8'($urandom) & ~HDR_OVF | HDR_SYNC,
                            8'($urandom), 8'($urandom));
                counted += 3;
            end
        end
        steady = 1'b0;
    endtask

    // result side stalls at random
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge aclk) begin
        mouse_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result: tuser %h tdata %h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (m_tuser[0] !== want.popped) begin
                    $error("popped: expected %0d, got %0d", want.popped, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata[8:0] !== want.move_x) begin
                    $error("move_x: expected %0d, got %0d",
                           $signed(want.move_x), $signed(m_tdata[8:0]));
                    mismatches++;
                end
                if (m_tdata[18:9] !== want.move_y) begin
                    $error("move_y: expected %0d, got %0d",
                           $signed(want.move_y), $signed(m_tdata[18:9]));
                    mismatches++;
                end
                if (m_tdata[21:19] !== want.buttons) begin
                    $error("button_bits: expected %0d, got %0d", want.buttons, m_tdata[21:19]);
                    mismatches++;
                end
                if (m_tdata[22] !== want.nonempty) begin
                    $error("queue_nonempty: expected %0d, got %0d", want.nonempty, m_tdata[22]);
                    mismatches++;
                end
                if (m_tdata[23] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %0d", m_tdata[23]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_ignored_bytes();
        test_packet_extremes();
        test_queue_full();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $error("%0d results never arrived", expected_reports.size());
            mismatches++;
        end
        $display("%0d items sent: %0d events queued, %0d dropped on a full queue, %0d overflow",
                 items_sent, events_kept, full_drops, ovf_drops);
        $display("pops: %0d returned an event, %0d found the queue empty; %0d mismatches",
                 pops_hit, pops_empty, mismatches);
        if (mismatches == 0) begin
            $display("ps2_mouse_packet_queue_core_test passed");
        end else begin
            $display("ps2_mouse_packet_queue_core_test failed");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("ps2_mouse_packet_queue_core_test failed");
        $finish;
    end

endmodule
